// File: rtl/twodo_pkg.sv
`timescale 1ns / 1ps

package twodo_pkg;

  // fixed point constants: angles Q4.28, trig values Q2.30
  localparam int CORDIC_STEPS = 28;
  localparam logic signed [33:0] Q_PI      = 34'sd843314857;
  localparam logic signed [33:0] Q_TWO_PI  = 34'sd1686629713;
  localparam logic signed [33:0] Q_HALF_PI = 34'sd421657428;
  localparam logic signed [31:0] COS_PI_6  = 32'sd929887697;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  // divider step counts for the three kinds of quotient
  localparam logic [6:0] STEPS_WHEEL = 7'd32;
  localparam logic [6:0] STEPS_TURN  = 7'd62;
  localparam logic [6:0] STEPS_VEL   = 7'd48;

  typedef enum logic [1:0] {
    CFG_PPM    = 2'd0,
    CFG_BASE   = 2'd1,
    CFG_PERIOD = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic signed [15:0] count_wheel_a;
    logic signed [15:0] count_wheel_b;
    logic signed [15:0] count_wheel_c;
  } odo_in_t;

  typedef struct packed {
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [31:0] pose_heading;
    logic signed [31:0] speed_x;
    logic signed [31:0] speed_y;
    logic signed [31:0] turn_rate;
  } odo_out_t;

  // request to one divider lane: numerator is left aligned, steps bits used
  typedef struct packed {
    logic        start;
    logic [6:0]  steps;
    logic [63:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic [63:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic               busy;
    logic signed [31:0] cos_v;
    logic signed [31:0] sin_v;
  } cordic_rsp_t;

  // arctangent of 2^-i in Q4.28
  function automatic logic signed [33:0] atan_step(input logic [4:0] i);
    logic signed [33:0] r;
    case (i)
      5'd0: r = 34'sd210828714;
      5'd1: r = 34'sd124459457;
      5'd2: r = 34'sd65760959;
      5'd3: r = 34'sd33381290;
      5'd4: r = 34'sd16755422;
      5'd5: r = 34'sd8385879;
      5'd6: r = 34'sd4193963;
      5'd7: r = 34'sd2097109;
      5'd8: r = 34'sd1048571;
      5'd9: r = 34'sd524287;
      default: r = 34'sd1 <<< (5'd28 - i);
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > 68'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -68'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // saturate a sign and magnitude quotient to 32 bit signed
  function automatic logic signed [31:0] sat_mag(input logic neg, input logic [63:0] mag);
    logic signed [31:0] r;
    if (neg) begin
      if (mag > 64'h0000_0000_8000_0000) begin
        r = 32'sh80000000;
      end else begin
        r = ~mag[31:0] + 32'd1;
      end
    end else begin
      if (mag > 64'h0000_0000_7FFF_FFFF) begin
        r = 32'sh7FFFFFFF;
      end else begin
        r = mag[31:0];
      end
    end
    return r;
  endfunction

endpackage

// File: rtl/twodo_div.sv
`timescale 1ns / 1ps

module twodo_div import twodo_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic        busy;
  logic [6:0]  cnt;
  logic [63:0] num;
  logic [63:0] quot;
  logic [31:0] den;
  logic [31:0] rem;
  logic [32:0] rem_s;
  logic [32:0] diff;
  logic        ge;

  // one restoring step per cycle
  assign rem_s = {rem, num[63]};
  assign diff  = rem_s - {1'b0, den};
  assign ge    = rem_s >= {1'b0, den};

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= req.steps;
    end else if (busy) begin
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) begin
        busy <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      num  <= req.num;
      den  <= req.den;
      rem  <= '0;
      quot <= '0;
    end else if (busy) begin
      num  <= {num[62:0], 1'b0};
      rem  <= ge ? diff[31:0] : rem_s[31:0];
      quot <= {quot[62:0], ge};
    end
  end

  assign rsp.busy = busy;
  assign rsp.quot = quot;

endmodule

// File: rtl/twodo_cordic.sv
`timescale 1ns / 1ps

module twodo_cordic import twodo_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] angle,
  output cordic_rsp_t        rsp
);

  logic               busy;
  logic [4:0]         idx;
  logic signed [33:0] x;
  logic signed [33:0] y;
  logic signed [33:0] z;
  logic               flip;
  logic signed [33:0] z0;
  logic signed [33:0] z1;
  logic signed [33:0] z2;
  logic               flip0;
  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic signed [33:0] xn;
  logic signed [33:0] yn;

  // reduce into [-pi, pi], then fold into [-pi/2, pi/2]
  always_comb begin
    z0 = 34'(angle);
    if (z0 > Q_PI) begin
      z1 = z0 - Q_TWO_PI;
    end else if (z0 < -Q_PI) begin
      z1 = z0 + Q_TWO_PI;
    end else begin
      z1 = z0;
    end
    flip0 = 1'b0;
    z2    = z1;
    if (z1 > Q_HALF_PI) begin
      z2    = z1 - Q_PI;
      flip0 = 1'b1;
    end else if (z1 < -Q_HALF_PI) begin
      z2    = z1 + Q_PI;
      flip0 = 1'b1;
    end
  end

  assign xs = x >>> idx;
  assign ys = y >>> idx;

  // iteration counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (busy) begin
      idx <= idx + 5'd1;
      if (idx == 5'(CORDIC_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // rotation datapath
  always_ff @(posedge clk) begin
    if (start) begin
      x    <= CORDIC_GAIN;
      y    <= '0;
      z    <= z2;
      flip <= flip0;
    end else if (busy) begin
      if (z >= 0) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - atan_step(idx);
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + atan_step(idx);
      end
    end
  end

  assign xn = -x;
  assign yn = -y;
  assign rsp.busy  = busy;
  assign rsp.cos_v = flip ? xn[31:0] : x[31:0];
  assign rsp.sin_v = flip ? yn[31:0] : y[31:0];

endmodule

// File: rtl/three_wheel_omni_odometry.sv
`timescale 1ns / 1ps
// channel  | direction | handshake               | payload
// in       | input     | in_valid / in_ready     | in_data (odo_in_t)
// out      | output    | out_valid / out_ready   | out_data (odo_out_t)
// cfg      | input     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// an item runs through the bit serial dividers in turn: 32 steps for wheel
// travel, 62 for heading change, 48 for twist (skipped when update_period is
// zero); cordic (28 steps) runs under the wheel division.
// rst is synchronous; it clears the pose, twist, stored counts and config registers.
// a finished result sits in the output register, so the next item is taken
// while out is stalled; cfg is always ready.

module three_wheel_omni_odometry import twodo_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  odo_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output odo_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_WHEEL  = 9'b000000010,
    S_MUL_DX = 9'b000000100,
    S_DX_RND = 9'b000001000,
    S_POSE   = 9'b000010000,
    S_POS_WR = 9'b000100000,
    S_THETA  = 9'b001000000,
    S_VEL    = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  state_t state;

  logic [15:0] ppm;
  logic [31:0] base_dia;
  logic [31:0] period;
  logic [15:0] ppm_eff;
  logic [31:0] base_eff;

  logic signed [15:0] prev_cnt [3];
  logic signed [15:0] cnt_in [3];
  logic signed [16:0] delta [3];
  logic        [15:0] delta_mag [3];
  logic               wheel_neg [3];
  logic signed [33:0] d [3];
  logic signed [33:0] d_val [3];

  logic signed [31:0] dx;
  logic signed [31:0] dy;
  logic signed [31:0] dth_v;
  logic signed [31:0] vel [3];
  logic signed [31:0] vel_in [3];
  logic [31:0]        vel_mag [3];
  logic               vel_neg [3];

  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] heading;
  logic signed [33:0] head_sum;
  logic signed [33:0] head_wrap;

  logic signed [35:0] sum01;
  logic signed [35:0] dy_w;
  logic signed [35:0] sum3;
  logic signed [35:0] sum3_n;
  logic               sum_neg;
  logic [33:0]        sum_mag;

  logic signed [34:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [66:0] mul_p;
  logic signed [66:0] prod;
  logic signed [66:0] dx_w;
  logic signed [65:0] acc_x;
  logic signed [65:0] acc_y;
  logic signed [65:0] rnd_x;
  logic signed [65:0] rnd_y;
  logic [2:0]         mul_cnt;

  logic        in_xfer;
  logic        lanes_idle;
  logic        vel_start;
  div_req_t    req [3];
  div_rsp_t    rsp [3];
  cordic_rsp_t trig;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && in_ready;
  assign ppm_eff   = (ppm == 16'd0) ? 16'd1 : ppm;
  assign base_eff  = (base_dia == 32'd0) ? 32'd1 : base_dia;
  assign lanes_idle = !rsp[0].busy && !rsp[1].busy && !rsp[2].busy;

  assign cnt_in[0] = in_data.count_wheel_a;
  assign cnt_in[1] = in_data.count_wheel_b;
  assign cnt_in[2] = in_data.count_wheel_c;

  // wheel deltas against the stored counts, as sign and magnitude
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      delta[i]     = 17'(cnt_in[i]) - 17'(prev_cnt[i]);
      delta_mag[i] = delta[i][16] ? 16'(-delta[i]) : delta[i][15:0];
      d_val[i]     = {1'b0, rsp[i].quot[32:0]};
    end
  end

  // body displacement terms from the wheel travel
  always_comb begin
    sum01   = 36'(d[0]) + 36'(d[1]);
    dy_w    = ((sum01 + 36'sd1) >>> 1) - 36'(d[2]);
    sum3    = sum01 + 36'(d[2]);
    sum3_n  = -sum3;
    sum_neg = sum3[35];
    sum_mag = sum_neg ? sum3_n[33:0] : sum3[33:0];
    dx_w    = (prod + 67'sd536870912) >>> 30;
    rnd_x   = (acc_x + 66'sd536870912) >>> 30;
    rnd_y   = (acc_y + 66'sd536870912) >>> 30;
    dth_v   = sat_mag(sum_neg, rsp[0].quot);
  end

  // heading update with a single wrap
  always_comb begin
    head_sum = 34'(heading) + 34'(dth_v);
    if (head_sum > Q_PI) begin
      head_wrap = head_sum - Q_TWO_PI;
    end else if (head_sum < -Q_PI) begin
      head_wrap = head_sum + Q_TWO_PI;
    end else begin
      head_wrap = head_sum;
    end
  end

  // twist inputs
  assign vel_in[0] = dx;
  assign vel_in[1] = dy;
  assign vel_in[2] = dth_v;
  assign vel_start = (state == S_THETA) && !rsp[0].busy && (period != 32'd0);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vel_mag[i] = vel_in[i][31] ? (~vel_in[i] + 32'd1) : vel_in[i];
    end
  end

  // lane requests
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      req[i].start = 1'b0;
      req[i].steps = STEPS_WHEEL;
      req[i].num   = {delta_mag[i], 48'd0};
      req[i].den   = {16'd0, ppm_eff};
      if (in_xfer) begin
        req[i].start = 1'b1;
      end else if (state == S_MUL_DX) begin
        if (i == 0) begin
          req[i].start = 1'b1;
          req[i].steps = STEPS_TURN;
          req[i].num   = {sum_mag, 30'd0};
          req[i].den   = base_eff;
        end
      end else if (vel_start) begin
        req[i].start = 1'b1;
        req[i].steps = STEPS_VEL;
        req[i].num   = {vel_mag[i], 32'd0};
        req[i].den   = period;
      end
    end
  end

  // divider lanes
  for (genvar g = 0; g < 3; g++) begin : g_lane
    twodo_div u_div (
      .clk (clk),
      .rst (rst),
      .req (req[g]),
      .rsp (rsp[g])
    );
  end

  twodo_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (in_xfer),
    .angle (heading),
    .rsp   (trig)
  );

  // shared multiplier operands
  always_comb begin
    mul_a = 35'(d[0]) - 35'(d[1]);
    mul_b = COS_PI_6;
    if (state == S_POSE) begin
      case (mul_cnt[2:1])
        2'd0: begin
          mul_a = 35'(dx);
          mul_b = trig.cos_v;
        end
        2'd1: begin
          mul_a = 35'(dy);
          mul_b = trig.sin_v;
        end
        2'd2: begin
          mul_a = 35'(dx);
          mul_b = trig.sin_v;
        end
        default: begin
          mul_a = 35'(dy);
          mul_b = trig.cos_v;
        end
      endcase
    end
  end

  assign mul_p = 67'(mul_a) * 67'(mul_b);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ppm      <= 16'd1;
      base_dia <= 32'd65536;
      period   <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PPM:    ppm      <= cfg_data[15:0];
        CFG_BASE:   base_dia <= cfg_data;
        CFG_PERIOD: period   <= cfg_data;
        default:    ;
      endcase
    end
  end

  // sequencer and odometry state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      mul_cnt   <= '0;
      pos_x     <= '0;
      pos_y     <= '0;
      heading   <= '0;
      for (int i = 0; i < 3; i++) begin
        prev_cnt[i] <= '0;
        vel[i]      <= '0;
      end
    end else begin
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            for (int i = 0; i < 3; i++) begin
              prev_cnt[i] <= cnt_in[i];
            end
            state <= S_WHEEL;
          end
        end
        S_WHEEL: begin
          if (lanes_idle && !trig.busy) begin
            state <= S_MUL_DX;
          end
        end
        S_MUL_DX: begin
          state <= S_DX_RND;
        end
        S_DX_RND: begin
          mul_cnt <= '0;
          state   <= S_POSE;
        end
        S_POSE: begin
          mul_cnt <= mul_cnt + 3'd1;
          if (mul_cnt == 3'd7) begin
            state <= S_POS_WR;
          end
        end
        S_POS_WR: begin
          pos_x <= sat32(68'(pos_x) + 68'(rnd_x));
          pos_y <= sat32(68'(pos_y) + 68'(rnd_y));
          state <= S_THETA;
        end
        S_THETA: begin
          if (!rsp[0].busy) begin
            heading <= sat32(68'(head_wrap));
            state   <= vel_start ? S_VEL : S_OUT;
          end
        end
        S_VEL: begin
          if (lanes_idle) begin
            for (int i = 0; i < 3; i++) begin
              vel[i] <= sat_mag(vel_neg[i], rsp[i].quot);
            end
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      for (int i = 0; i < 3; i++) begin
        wheel_neg[i] <= delta[i][16];
      end
    end
    if (state == S_WHEEL && lanes_idle) begin
      for (int i = 0; i < 3; i++) begin
        d[i] <= wheel_neg[i] ? -d_val[i] : d_val[i];
      end
    end
    if (state == S_MUL_DX) begin
      prod <= mul_p;
      dy   <= sat32(68'(dy_w));
    end
    if (state == S_DX_RND) begin
      dx <= sat32(68'(dx_w));
    end
    if (state == S_POSE) begin
      if (!mul_cnt[0]) begin
        prod <= mul_p;
      end else begin
        case (mul_cnt[2:1])
          2'd0:    acc_x <= 66'(prod);
          2'd1:    acc_x <= acc_x - 66'(prod);
          2'd2:    acc_y <= 66'(prod);
          default: acc_y <= acc_y + 66'(prod);
        endcase
      end
    end
    if (vel_start) begin
      for (int i = 0; i < 3; i++) begin
        vel_neg[i] <= vel_in[i][31];
      end
    end
    if (state == S_OUT && (!out_valid || out_ready)) begin
      out_data.pose_x       <= pos_x;
      out_data.pose_y       <= pos_y;
      out_data.pose_heading <= heading;
      out_data.speed_x      <= vel[0];
      out_data.speed_y      <= vel[1];
      out_data.turn_rate    <= vel[2];
    end
  end

endmodule

// File: rtl/twodo_checker.sv
`timescale 1ns / 1ps

module twodo_checker import twodo_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input odo_out_t out_data,
  input logic     cfg_valid,
  input logic     cfg_ready
);

  // a stalled result stays offered with the same payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  // one item at a time: after a transfer in, input is closed
  a_in_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input open right after a transfer");

  // no result straight out of reset
  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result after reset");

  // a result never appears in the cycle after an input transfer
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result too early");

  // configuration is always taken
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("config write stalled");

endmodule

bind three_wheel_omni_odometry twodo_checker u_twodo_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);
